/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define MDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checked at every clock edge, reset included.
`define MDC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/mdc_pkg.sv */
package mdc_pkg;

	localparam logic [2:0] CFG_GAIN    = 3'd0;
	localparam logic [2:0] CFG_CAP     = 3'd1;
	localparam logic [2:0] CFG_SMOOTH  = 3'd2;
	localparam logic [2:0] CFG_DECEL   = 3'd3;
	localparam logic [2:0] CFG_INERTIA = 3'd4;

	localparam logic [12:0] DT_MAX      = 13'd6554;
	localparam logic [19:0] TEN_FX      = 20'd655360;
	localparam logic [15:0] NINE_TENTHS = 16'd58982;
	localparam logic [40:0] SMALL_LEN2  = 41'd429496;
	localparam logic [31:0] S_OFF_MAX   = 32'd6;
	localparam logic [31:0] S_BLEND_MAX = 32'd65529;
	localparam logic [31:0] S_AVG_MAX   = 32'd65542;
	localparam logic [16:0] FX_ONE      = 17'd65536;
	// 2^23 / 10, rounded up; exact floor(y/10) for y below 2^20
	localparam logic [33:0] RECIP_TEN   = 34'd838861;

	localparam logic [1:0] CHG_NONE  = 2'd0;
	localparam logic [1:0] CHG_PRESS = 2'd1;
	localparam logic [1:0] CHG_REL   = 2'd2;

	typedef enum logic [1:0] {
		SM_OFF,
		SM_BLEND,
		SM_AVG,
		SM_TIMED
	} smode_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PLAIN,
		OP_ACC_SQ,
		OP_ACC_G,
		OP_ACC_WR,
		OP_BL_SQ,
		OP_TM_SQ,
		OP_SUM,
		OP_SQ_START,
		OP_BL_LM,
		OP_BL_DV,
		OP_BL_AMT,
		OP_TM_R,
		OP_TM_AMT,
		OP_AP_MUL,
		OP_AP_WR,
		OP_AVG,
		OP_IN_K,
		OP_IN_KW,
		OP_IN_MUL,
		OP_IN_WR,
		OP_OUT
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PLAIN,
		ST_ACC_SQ,
		ST_ACC_G,
		ST_ACC_WR,
		ST_BL_SQ,
		ST_BL_SUM,
		ST_SQ_START,
		ST_SQ_WAIT,
		ST_BL_LM,
		ST_BL_DV,
		ST_BL_AMT,
		ST_TM_SQ,
		ST_TM_SUM,
		ST_TM_R,
		ST_TM_AMT,
		ST_AP_MUL,
		ST_AP_WR,
		ST_AVG,
		ST_IN_K,
		ST_IN_KW,
		ST_IN_MUL,
		ST_IN_WR,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic axis;
	} cmd_t;

	typedef struct packed {
		logic   gain_on;
		smode_t smode;
		logic   inert_on;
		logic   sq_busy;
		logic   out_free;
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -68'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/mouse_delta_conditioner.sv */
// Fewest steps from input to output word with no acceleration, smoothing off and no inertia; most with
// acceleration, blend smoothing with its square-root wait, and inertia.
// A new input word is taken only in idle, after the last has reached the output register, which a stalled
// output word holds back. The sequencer steps the shared multiplier and square-root unit for x then y.
// Reset (arst_n low, asynchronous): configuration registers, history, inertia and wheel state cleared.
module mouse_delta_conditioner (
	input  logic         clk,
	input  logic         arst_n,
	// configuration writes
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// input words
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// raw_dx[15:0], raw_dy[31:16], raw_wheel[47:32], frame_time[63:48]
	input  logic [63:0]  s_axis_tdata,
	// result words
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// move_x[31:0], move_y[63:32], wheel_out[79:64], moved[80],
	// wheel_up_change[82:81], wheel_down_change[84:83], held_x[116:85],
	// held_y[148:117], zero[151:149]
	output logic [151:0] m_axis_tdata
);
	import mdc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: one state per arithmetic step, x then y
	mdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: config, history, shared multiplier, square root, output register
	mdc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_data  (m_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule

/* hw/rtl/mdc_sqrt.sv */
module mdc_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [40:0] val,
	output logic        busy,
	output logic [20:0] root
);
	logic [41:0] val_q;
	logic [22:0] rem_q;
	logic [20:0] root_q;
	logic [4:0]  cnt_q;
	logic [24:0] rem_t;
	logic [24:0] trial;
	logic        fits;

	// one result bit per cycle, restoring method
	assign rem_t = {rem_q, val_q[41:40]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = rem_t >= trial;
	assign busy  = cnt_q != 5'd0;
	assign root  = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0;
		end else if (start) begin
			cnt_q <= 5'd21;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= {1'b0, val};
			rem_q  <= 23'd0;
			root_q <= 21'd0;
		end else if (busy) begin
			val_q <= {val_q[39:0], 2'b00};
			if (fits) begin
				rem_q  <= rem_t[22:0] - trial[22:0];
				root_q <= {root_q[19:0], 1'b1};
			end else begin
				rem_q  <= rem_t[22:0];
				root_q <= {root_q[19:0], 1'b0};
			end
		end
	end
endmodule

/* hw/rtl/mdc_ctrl.sv */
module mdc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  mdc_pkg::sts_t sts,
	output mdc_pkg::cmd_t cmd
);
	import mdc_pkg::*;

	state_t state_q, state_d;
	logic   axis_q;
	state_t after_acc, after_smooth;

	always_comb begin
		after_smooth = sts.inert_on ? ST_IN_K : ST_OUT;
		case (sts.smode)
			SM_OFF:   after_acc = after_smooth;
			SM_BLEND: after_acc = ST_BL_SQ;
			SM_AVG:   after_acc = ST_AVG;
			SM_TIMED: after_acc = ST_TM_SQ;
			default:  after_acc = after_smooth;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = sts.gain_on ? ST_ACC_SQ : ST_PLAIN;
			ST_PLAIN:    state_d = after_acc;
			ST_ACC_SQ:   state_d = ST_ACC_G;
			ST_ACC_G:    state_d = ST_ACC_WR;
			ST_ACC_WR:   state_d = axis_q ? after_acc : ST_ACC_SQ;
			ST_BL_SQ:    state_d = ST_BL_SUM;
			ST_BL_SUM:   state_d = axis_q ? ST_SQ_START : ST_BL_SQ;
			ST_SQ_START: state_d = ST_SQ_WAIT;
			ST_SQ_WAIT:  if (!sts.sq_busy) state_d = ST_BL_LM;
			ST_BL_LM:    state_d = ST_BL_DV;
			ST_BL_DV:    state_d = ST_BL_AMT;
			ST_BL_AMT:   state_d = ST_AP_MUL;
			ST_TM_SQ:    state_d = ST_TM_SUM;
			ST_TM_SUM:   state_d = axis_q ? ST_TM_R : ST_TM_SQ;
			ST_TM_R:     state_d = ST_TM_AMT;
			ST_TM_AMT:   state_d = ST_AP_MUL;
			ST_AP_MUL:   state_d = ST_AP_WR;
			ST_AP_WR:    state_d = axis_q ? after_smooth : ST_AP_MUL;
			ST_AVG:      state_d = after_smooth;
			ST_IN_K:     state_d = ST_IN_KW;
			ST_IN_KW:    state_d = ST_IN_MUL;
			ST_IN_MUL:   state_d = ST_IN_WR;
			ST_IN_WR:    state_d = axis_q ? ST_OUT : ST_IN_MUL;
			ST_OUT:      if (sts.out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.axis = axis_q;
		cmd.op   = OP_NONE;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.op = OP_LOAD;
			end
			ST_PLAIN:    cmd.op = OP_PLAIN;
			ST_ACC_SQ:   cmd.op = OP_ACC_SQ;
			ST_ACC_G:    cmd.op = OP_ACC_G;
			ST_ACC_WR:   cmd.op = OP_ACC_WR;
			ST_BL_SQ:    cmd.op = OP_BL_SQ;
			ST_BL_SUM:   cmd.op = OP_SUM;
			ST_SQ_START: cmd.op = OP_SQ_START;
			ST_SQ_WAIT:  cmd.op = OP_NONE;
			ST_BL_LM:    cmd.op = OP_BL_LM;
			ST_BL_DV:    cmd.op = OP_BL_DV;
			ST_BL_AMT:   cmd.op = OP_BL_AMT;
			ST_TM_SQ:    cmd.op = OP_TM_SQ;
			ST_TM_SUM:   cmd.op = OP_SUM;
			ST_TM_R:     cmd.op = OP_TM_R;
			ST_TM_AMT:   cmd.op = OP_TM_AMT;
			ST_AP_MUL:   cmd.op = OP_AP_MUL;
			ST_AP_WR:    cmd.op = OP_AP_WR;
			ST_AVG:      cmd.op = OP_AVG;
			ST_IN_K:     cmd.op = OP_IN_K;
			ST_IN_KW:    cmd.op = OP_IN_KW;
			ST_IN_MUL:   cmd.op = OP_IN_MUL;
			ST_IN_WR:    cmd.op = OP_IN_WR;
			ST_OUT:      if (sts.out_free) cmd.op = OP_OUT;
			default:     cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// every per-axis group runs x then y and ends back on x
			if (state_q == ST_ACC_WR || state_q == ST_BL_SUM || state_q == ST_TM_SUM ||
			    state_q == ST_AP_WR || state_q == ST_IN_WR) begin
				axis_q <= ~axis_q;
			end
		end
	end
endmodule

/* hw/rtl/mdc_dp.sv */
module mdc_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic [63:0]    in_data,
	output logic [151:0]   out_data,
	output logic           out_valid,
	input  logic           out_ready,
	input  mdc_pkg::cmd_t  cmd,
	output mdc_pkg::sts_t  sts
);
	import mdc_pkg::*;

	logic [31:0] gain_q, cap_q, smooth_q, decel_q, inertia_q;
	logic signed [15:0] dx_q, dy_q, wh_q;
	logic [12:0] dt_q;
	logic signed [31:0] cx_q, cy_q, prev_x_q, prev_y_q, inert_x_q, inert_y_q;
	logic wup_q, wdn_q;
	logic signed [67:0] prod_q, prod_d;
	logic signed [33:0] op_a, op_b;
	logic [40:0] sum_q;
	logic [16:0] amt_q;
	logic [28:0] k_q;
	logic        out_valid_q;
	logic [151:0] out_q;

	logic signed [15:0] d_sel;
	logic signed [31:0] c_sel, p_sel, i_sel;
	logic signed [32:0] e_sel, ci_sel, ex, ey;
	logic [32:0] aex, aey;
	logic far, near_zero, stopping, sq_busy;
	logic [20:0] root;
	logic [19:0] len;
	logic [15:0] ms;
	logic [32:0] rate;
	logic [31:0] capped;
	logic signed [31:0] acc_v, ap_v, in_v;
	logic signed [32:0] avg_x, avg_y;
	logic [29:0] tm_t;
	logic [15:0] ft;
	logic up_press, dn_press;
	logic [1:0] up_chg, dn_chg;
	logic signed [31:0] hx, hy;
	logic moved;

	assign ft = in_data[63:48];

	always_comb begin
		d_sel = cmd.axis ? dy_q : dx_q;
		c_sel = cmd.axis ? cy_q : cx_q;
		p_sel = cmd.axis ? prev_y_q : prev_x_q;
		i_sel = cmd.axis ? inert_y_q : inert_x_q;
		e_sel  = {c_sel[31], c_sel} - {p_sel[31], p_sel};
		ci_sel = {c_sel[31], c_sel} - {i_sel[31], i_sel};
		ex  = {cx_q[31], cx_q} - {prev_x_q[31], prev_x_q};
		ey  = {cy_q[31], cy_q} - {prev_y_q[31], prev_y_q};
		aex = ex[32] ? 33'(-ex) : 33'(ex);
		aey = ey[32] ? 33'(-ey) : 33'(ey);
		far = (aex > {13'd0, TEN_FX}) || (aey > {13'd0, TEN_FX});
		near_zero = (cx_q > -32'sd65536) && (cx_q < 32'sd65536) &&
		            (cy_q > -32'sd65536) && (cy_q < 32'sd65536);
		stopping = near_zero && (sum_q <= SMALL_LEN2);
		if (stopping) begin
			rate = (decel_q > S_OFF_MAX) ? {1'b0, decel_q} : {smooth_q, 1'b0};
		end else begin
			rate = {1'b0, smooth_q};
		end
		if (far || root > {1'b0, TEN_FX}) len = TEN_FX;
		else len = root[19:0];
		ms = (smooth_q < {16'd0, NINE_TENTHS}) ? smooth_q[15:0] : NINE_TENTHS;
	end

	// shared multiplier, registered
	always_comb begin
		op_a = 34'sd0;
		op_b = 34'sd0;
		case (cmd.op)
			OP_ACC_SQ: begin
				op_a = {{18{d_sel[15]}}, d_sel};
				op_b = {{18{d_sel[15]}}, d_sel};
			end
			OP_ACC_G: begin
				op_a = {3'b000, prod_q[30:0]};
				op_b = {2'b00, gain_q};
			end
			OP_BL_SQ: begin
				op_a = {e_sel[32], e_sel};
				op_b = {e_sel[32], e_sel};
			end
			OP_TM_SQ: begin
				op_a = {{2{c_sel[31]}}, c_sel};
				op_b = {{2{c_sel[31]}}, c_sel};
			end
			OP_BL_LM: begin
				op_a = {14'd0, len};
				op_b = {18'd0, ms};
			end
			OP_BL_DV: begin
				op_a = {14'd0, prod_q[35:16]};
				op_b = RECIP_TEN;
			end
			OP_TM_R: begin
				op_a = {21'd0, dt_q};
				op_b = {1'b0, rate};
			end
			OP_AP_MUL: begin
				op_a = {e_sel[32], e_sel};
				op_b = {17'd0, amt_q};
			end
			OP_IN_K: begin
				op_a = {21'd0, dt_q};
				op_b = {2'b00, inertia_q};
			end
			OP_IN_MUL: begin
				op_a = {ci_sel[32], ci_sel};
				op_b = {5'd0, k_q};
			end
			default: begin
				op_a = 34'sd0;
				op_b = 34'sd0;
			end
		endcase
	end

	assign prod_d = op_a * op_b;

	always_comb begin
		// accelerated magnitude, capped, then signed and saturated
		capped = (prod_q[62:0] > {31'd0, cap_q}) ? cap_q : prod_q[31:0];
		if (d_sel[15]) begin
			acc_v = (capped > 32'h80000000) ? 32'sh80000000 : 32'(-capped);
		end else begin
			acc_v = (capped > 32'h7FFFFFFF) ? 32'sh7FFFFFFF : capped;
		end
		// both terms signed so the shift floors negative products
		ap_v  = sat32($signed({{36{p_sel[31]}}, p_sel}) + (prod_q >>> 16));
		in_v  = sat32($signed({{36{i_sel[31]}}, i_sel}) + (prod_q >>> 16));
		avg_x = {cx_q[31], cx_q} + {prev_x_q[31], prev_x_q};
		avg_y = {cy_q[31], cy_q} + {prev_y_q[31], prev_y_q};
		tm_t  = prod_q[45:16];
		up_press = (wh_q > 16'sd0);
		dn_press = (wh_q < 16'sd0);
		up_chg = (wup_q && !up_press) ? CHG_REL : ((!wup_q && up_press) ? CHG_PRESS : CHG_NONE);
		dn_chg = (wdn_q && !dn_press) ? CHG_REL : ((!wdn_q && dn_press) ? CHG_PRESS : CHG_NONE);
		moved = (cx_q != 32'sd0) || (cy_q != 32'sd0) || (wh_q != 16'sd0);
		hx = (inertia_q != 32'd0) ? inert_x_q : cx_q;
		hy = (inertia_q != 32'd0) ? inert_y_q : cy_q;
	end

	mdc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.op == OP_SQ_START),
		.val    (sum_q),
		.busy   (sq_busy),
		.root   (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q    <= 32'd0;
			cap_q     <= 32'd0;
			smooth_q  <= 32'd0;
			decel_q   <= 32'd0;
			inertia_q <= 32'd0;
			prev_x_q  <= 32'sd0;
			prev_y_q  <= 32'sd0;
			inert_x_q <= 32'sd0;
			inert_y_q <= 32'sd0;
			wup_q     <= 1'b0;
			wdn_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GAIN:    gain_q    <= cfg_data;
					CFG_CAP:     cap_q     <= cfg_data;
					CFG_SMOOTH:  smooth_q  <= cfg_data;
					CFG_DECEL:   decel_q   <= cfg_data;
					CFG_INERTIA: inertia_q <= cfg_data;
					default: ;
				endcase
			end
			case (cmd.op)
				OP_AP_WR: begin
					if (cmd.axis) prev_y_q <= ap_v;
					else prev_x_q <= ap_v;
				end
				OP_AVG: begin
					prev_x_q <= avg_x[32:1];
					prev_y_q <= avg_y[32:1];
				end
				OP_IN_WR: begin
					if (cmd.axis) inert_y_q <= in_v;
					else inert_x_q <= in_v;
				end
				OP_OUT: begin
					if (up_chg != CHG_NONE) wup_q <= up_press;
					if (dn_chg != CHG_NONE) wdn_q <= dn_press;
				end
				default: ;
			endcase
			if (cmd.op == OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (cmd.op)
			OP_LOAD: begin
				dx_q <= in_data[15:0];
				dy_q <= in_data[31:16];
				wh_q <= in_data[47:32];
				dt_q <= (ft > {3'd0, DT_MAX}) ? DT_MAX : ft[12:0];
			end
			OP_PLAIN: begin
				cx_q <= {dx_q, 16'h0000};
				cy_q <= {dy_q, 16'h0000};
			end
			OP_ACC_WR: begin
				if (cmd.axis) cy_q <= acc_v;
				else cx_q <= acc_v;
			end
			OP_SUM: sum_q <= (cmd.axis ? sum_q : 41'd0) + prod_q[40:0];
			OP_BL_AMT: amt_q <= FX_ONE - {1'b0, prod_q[38:23]};
			OP_TM_AMT: amt_q <= (tm_t > {13'd0, FX_ONE}) ? FX_ONE : tm_t[16:0];
			OP_AP_WR: begin
				if (cmd.axis) cy_q <= ap_v;
				else cx_q <= ap_v;
			end
			OP_AVG: begin
				cx_q <= avg_x[32:1];
				cy_q <= avg_y[32:1];
			end
			OP_IN_KW: k_q <= prod_q[44:16];
			OP_OUT: out_q <= {3'b000, hy, hx, dn_chg, up_chg, moved, wh_q, cy_q, cx_q};
			default: ;
		endcase
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	always_comb begin
		sts.gain_on  = gain_q != 32'd0;
		sts.inert_on = inertia_q != 32'd0;
		sts.sq_busy  = sq_busy;
		sts.out_free = !out_valid_q || out_ready;
		if (smooth_q <= S_OFF_MAX) sts.smode = SM_OFF;
		else if (smooth_q <= S_BLEND_MAX) sts.smode = SM_BLEND;
		else if (smooth_q <= S_AVG_MAX) sts.smode = SM_AVG;
		else sts.smode = SM_TIMED;
	end
endmodule

/* hw/rtl/mdc_checker.sv */
`include "assert_macros.svh"

module mdc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [151:0] m_axis_tdata
);
	`MDC_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_axis_tvalid, "result word during reset")
	`MDC_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled word dropped or changed")
	`MDC_ASSERT(a_busy, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second word taken while busy")
	`MDC_ASSERT(a_moved, m_axis_tvalid && m_axis_tdata[79:64] != 16'd0 |-> m_axis_tdata[80], "wheel moved without moved flag")
endmodule

bind mouse_delta_conditioner mdc_checker u_chk (.*);
